### rtl/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types and codes for the Latin hypercube point store.
// ----------------------------------------------------------------------------
package lhs_pkg;

    localparam logic [2:0] MODE_ADD_IDX   = 3'd0;
    localparam logic [2:0] MODE_ADD_COORD = 3'd1;
    localparam logic [2:0] MODE_PROBE     = 3'd2;
    localparam logic [2:0] MODE_PAIRWISE  = 3'd3;
    localparam logic [2:0] MODE_CLEAR     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int FIELD_W = 4;
    localparam int PACK_FIELDS = 4;
    localparam int DIST_W = 10;
    localparam logic [DIST_W-1:0] DIST_SAT = 10'd1023;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] packed_values;
    } t_req;

    typedef struct packed {
        logic [9:0]  distance;
        logic [15:0] resolved_point;
        logic [4:0]  point_count;
        logic [1:0]  status;
    } t_rsp;

    // Distance unit control from the sequencer
    typedef struct packed {
        logic clear;
        logic acc;
        logic fold;
    } t_dist_ctl;

endpackage

### rtl/latin_hypercube_maximin_store.sv
// ----------------------------------------------------------------------------
// latin_hypercube_maximin_store
// Latin hypercube point store with maximin distance queries.
// ----------------------------------------------------------------------------
// One request at a time; a single squared-distance unit handles one
// dimension at a time (store read, then accumulate) and then folds each
// point into a running minimum. An add by index reads each dimension's
// remaining-list entry, walks the distance over every stored point, and
// then swap-removes the used entries. An add by coordinates replaces the
// index reads with a search of each list for the value. A probe is an add
// by index without the swap-remove. Pairwise loads each first point from
// the store and then walks the distance over every later point. After
// reset or a clear request the remaining lists are refilled by a sweep
// during which no request is taken. The result waits in an output
// register; a new request is taken once it has been delivered.
module latin_hypercube_maximin_store #(
    parameter int DIMS   = 4,
    parameter int POINTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lhs_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output lhs_pkg::t_rsp   o_rsp
);
    localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int PW = $clog2(POINTS);
    localparam int CW = $clog2(POINTS + 1);
    localparam int AW = $clog2(DIMS * POINTS);
    localparam int PSA = $clog2(POINTS * DIMS);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_RDV    = 4'd3;  // read remaining value
    localparam logic [3:0] S_RDV2   = 4'd4;
    localparam logic [3:0] S_SRCH   = 4'd5;
    localparam logic [3:0] S_SRCH2  = 4'd6;
    localparam logic [3:0] S_DRD    = 4'd7;  // issue store read
    localparam logic [3:0] S_DACC   = 4'd8;
    localparam logic [3:0] S_FOLD   = 4'd9;
    localparam logic [3:0] S_UPD    = 4'd10;
    localparam logic [3:0] S_UPD2   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // remaining lists and point store
    logic [3:0] r_rem [DIMS*POINTS];
    logic [3:0] r_pts [POINTS*DIMS];
    logic [3:0] r_rem_q, r_pts_q;
    logic [CW-1:0] r_cnt [DIMS];

    logic [3:0]    r_state;
    logic [2:0]    r_mode;
    logic [15:0]   r_pv;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_j;      // search index / point i
    logic [CW-1:0] r_k;      // point j for pairwise
    logic [CW-1:0] r_np;
    logic [AW-1:0] r_init;
    logic [3:0]    r_pt  [DIMS];
    logic [CW-1:0] r_pos [DIMS];
    logic [1:0]    r_stat;
    logic          r_ovalid;
    lhs_pkg::t_rsp r_rsp;
    logic          r_cand;   // pairwise: r_pt holds point r_j

    lhs_pkg::t_dist_ctl w_ctl;
    logic [lhs_pkg::DIST_W-1:0] w_min;
    logic [3:0] w_field;
    logic [3:0] w_b;
    logic [15:0] w_packed;
    logic w_last_d;

    assign w_last_d = (r_d == DW'(DIMS - 1));
    assign w_field = (r_d < DW'(lhs_pkg::PACK_FIELDS) || DIMS <= lhs_pkg::PACK_FIELDS)
                   ? r_pv[{r_d[1:0], 2'b00} +: 4] : 4'd0;

    always_comb begin
        w_packed = '0;
        for (int d = 0; d < DIMS && d < lhs_pkg::PACK_FIELDS; d++) begin
            w_packed[4*d +: 4] = r_pt[d];
        end
    end

    // second operand: candidate coordinate, or point r_j's (pairwise)
    assign w_b = r_pt[r_d];

    lhs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (r_pts_q),
        .i_b     (w_b),
        .o_min   (w_min)
    );

    // hold the accumulator while a pairwise first point is being loaded
    always_comb begin
        w_ctl = '0;
        w_ctl.clear = (r_state == S_IDLE);
        w_ctl.acc   = (r_state == S_DACC)
                   && !(r_mode == lhs_pkg::MODE_PAIRWISE && !r_cand);
        w_ctl.fold  = (r_state == S_FOLD);
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    logic [AW-1:0] w_rem_addr;
    logic [PSA-1:0] w_pts_addr;
    logic [CW-1:0] w_pidx;

    // in pairwise, r_pt holds point r_j once loaded; walk r_k over later points
    assign w_pidx = (r_mode == lhs_pkg::MODE_PAIRWISE && r_cand) ? r_k : r_j;
    assign w_pts_addr = PSA'(w_pidx[PW-1:0] * DIMS + r_d);

    always_ff @(posedge i_clk) begin
        r_pts_q <= r_pts[w_pts_addr];
        r_rem_q <= r_rem[w_rem_addr];
    end

    // index reads address the list straight from the request field
    assign w_rem_addr = (r_state == S_UPD)
                      ? AW'(r_d * POINTS + (r_cnt[r_d] - CW'(1)))
                      : (r_state == S_RDV)
                      ? AW'(r_d * POINTS + int'(w_field))
                      : AW'(r_d * POINTS + r_j[PW-1:0]);

    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT) begin
            r_rem[r_init] <= 4'(r_init % POINTS);
        end else if (r_state == S_UPD2) begin
            r_rem[AW'(r_d * POINTS + r_pos[r_d][PW-1:0])] <= r_rem_q;
        end
        if (r_state == S_UPD2) begin
            r_pts[PSA'(r_np[PW-1:0] * DIMS + r_d)] <= r_pt[r_d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_np     <= '0;
            r_ovalid <= 1'b0;
            r_d      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_cand   <= 1'b0;
            for (int d = 0; d < DIMS; d++) r_cnt[d] <= CW'(POINTS);
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    // refill the remaining lists
                    r_init <= r_init + AW'(1);
                    if (r_init == AW'(DIMS * POINTS - 1)) begin
                        r_state <= S_IDLE;
                        r_init  <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode <= i_req.mode;
                        r_pv   <= i_req.packed_values;
                        r_d    <= '0;
                        r_j    <= '0;
                        r_k    <= '0;
                        r_cand <= 1'b0;
                        r_stat <= lhs_pkg::ST_OK;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    case (r_mode)
                        lhs_pkg::MODE_ADD_IDX, lhs_pkg::MODE_ADD_COORD: begin
                            if (r_np >= CW'(POINTS)) begin
                                r_stat  <= lhs_pkg::ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= (r_mode == lhs_pkg::MODE_ADD_IDX) ? S_RDV
                                                                             : S_SRCH;
                            end
                        end
                        lhs_pkg::MODE_PROBE: r_state <= S_RDV;
                        lhs_pkg::MODE_PAIRWISE: begin
                            // load point 0 coords into r_pt via store reads
                            r_j <= '0;
                            r_k <= CW'(1);
                            r_state <= (r_np <= CW'(1)) ? S_DONE : S_DRD;
                        end
                        lhs_pkg::MODE_CLEAR: begin
                            r_np <= '0;
                            for (int d = 0; d < DIMS; d++) r_cnt[d] <= CW'(POINTS);
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_stat  <= lhs_pkg::ST_RANGE;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RDV: begin
                    // index check, then read the list entry
                    if (CW'(w_field) >= r_cnt[r_d]) begin
                        r_stat  <= lhs_pkg::ST_RANGE;
                        r_state <= S_DONE;
                    end else begin
                        r_j     <= CW'(w_field);
                        r_state <= S_RDV2;
                    end
                end
                S_RDV2: begin
                    r_pt[r_d]  <= r_rem_q;
                    r_pos[r_d] <= r_j;
                    if (w_last_d) begin
                        r_d <= '0; r_j <= '0;
                        // empty store: skip the distance walk; a probe is done
                        if (r_np != '0) begin
                            r_state <= S_DRD;
                        end else begin
                            r_state <= (r_mode == lhs_pkg::MODE_PROBE) ? S_DONE : S_UPD;
                        end
                    end else begin
                        r_d <= r_d + DW'(1);
                        r_state <= S_RDV;
                    end
                end
                S_SRCH: begin
                    if (r_j >= r_cnt[r_d]) begin
                        r_stat  <= lhs_pkg::ST_RANGE;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SRCH2;
                    end
                end
                S_SRCH2: begin
                    if (r_rem_q == w_field) begin
                        r_pt[r_d]  <= w_field;
                        r_pos[r_d] <= r_j;
                        r_j <= '0;
                        if (w_last_d) begin
                            r_d <= '0;
                            r_state <= (r_np == '0) ? S_UPD : S_DRD;
                        end else begin
                            r_d <= r_d + DW'(1);
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_j <= r_j + CW'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_DRD: r_state <= S_DACC;
                S_DACC: begin
                    if (r_mode == lhs_pkg::MODE_PAIRWISE && !r_cand) begin
                        // loading point r_j into r_pt; no accumulate wanted
                        r_pt[r_d] <= r_pts_q;
                    end
                    if (w_last_d) begin
                        r_d <= '0;
                        if (r_mode == lhs_pkg::MODE_PAIRWISE && !r_cand) begin
                            r_cand  <= 1'b1;
                            r_state <= S_DRD;
                        end else begin
                            r_state <= S_FOLD;
                        end
                    end else begin
                        r_d <= r_d + DW'(1);
                        r_state <= S_DRD;
                    end
                end
                S_FOLD: begin
                    if (r_mode == lhs_pkg::MODE_PAIRWISE) begin
                        if (r_k + CW'(1) < r_np) begin
                            r_k <= r_k + CW'(1);
                            r_state <= S_DRD;
                        end else if (r_j + CW'(2) < r_np) begin
                            r_j <= r_j + CW'(1);
                            r_k <= r_j + CW'(2);
                            r_cand <= 1'b0;
                            r_state <= S_DRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (r_j + CW'(1) < r_np) begin
                        r_j <= r_j + CW'(1);
                        r_state <= S_DRD;
                    end else begin
                        r_d <= '0;
                        r_state <= (r_mode == lhs_pkg::MODE_PROBE) ? S_DONE : S_UPD;
                    end
                end
                S_UPD: r_state <= S_UPD2;
                S_UPD2: begin
                    // swap-remove: move last entry into the used slot
                    r_cnt[r_d] <= r_cnt[r_d] - CW'(1);
                    if (w_last_d) begin
                        r_np <= r_np + CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_d <= r_d + DW'(1);
                        r_state <= S_UPD;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_rsp.status <= r_stat;
                    r_rsp.point_count <= r_np;
                    r_rsp.resolved_point <= '0;
                    r_rsp.distance <= '0;
                    if (r_stat == lhs_pkg::ST_OK) begin
                        case (r_mode)
                            lhs_pkg::MODE_ADD_IDX, lhs_pkg::MODE_ADD_COORD,
                            lhs_pkg::MODE_PROBE: begin
                                r_rsp.resolved_point <= w_packed;
                                r_rsp.distance <= w_min;
                            end
                            lhs_pkg::MODE_PAIRWISE: r_rsp.distance <= w_min;
                            default: ;
                        endcase
                    end
                    r_state <= (r_mode == lhs_pkg::MODE_CLEAR && r_stat == lhs_pkg::ST_OK)
                             ? S_INIT : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // assertions
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_np <= CW'(POINTS)) else $error("point count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("no result after done");
endmodule

### rtl/lhs_dist.sv
// ----------------------------------------------------------------------------
// lhs_dist
// Shared squared-distance unit: one dimension per cycle while acc is set,
// then fold into a running minimum.
// ----------------------------------------------------------------------------
module lhs_dist (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lhs_pkg::t_dist_ctl    i_ctl,
    input  logic [3:0]            i_a,
    input  logic [3:0]            i_b,
    output logic [lhs_pkg::DIST_W-1:0] o_min
);
    logic [3:0]  w_diff;
    logic [7:0]  w_sq;
    logic [10:0] r_sum;
    logic [10:0] n_sum;
    logic [10:0] r_min;
    logic        r_any;

    assign w_diff = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
    assign w_sq   = w_diff * w_diff;
    assign n_sum  = r_sum + {3'b0, w_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_min <= '0;
            r_any <= 1'b0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
            r_min <= '0;
            r_any <= 1'b0;
        end else if (i_ctl.acc) begin
            r_sum <= n_sum;
        end else if (i_ctl.fold) begin
            if (!r_any || r_sum < r_min) begin
                r_min <= r_sum;
            end
            r_any <= 1'b1;
            r_sum <= '0;
        end
    end

    assign o_min = (r_min > {1'b0, lhs_pkg::DIST_SAT}) ? lhs_pkg::DIST_SAT
                                                       : r_min[lhs_pkg::DIST_W-1:0];
endmodule

### tb/sv/latin_hypercube_maximin_store_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latin_hypercube_maximin_store_test
// Self-checking bench for the Latin hypercube point store.
// ----------------------------------------------------------------------------
// Requests go in through a bursty sender. A behavioral copy of the store
// works out the response for each accepted request. A checker pops each
// expected response as the block delivers one, while the output side stalls
// on its own pattern. Tests cover directed corner cases, well-formed fill
// sequences with random content, and random noise.
// ----------------------------------------------------------------------------
module latin_hypercube_maximin_store_test;

    localparam int NDIM = 4;
    localparam int NPTS = 16;
    localparam int CYCLE_LIMIT = 10000000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    lhs_pkg::t_req  i_req;
    logic           o_valid;
    logic           i_ready;
    lhs_pkg::t_rsp  o_rsp;

    latin_hypercube_maximin_store #(.DIMS(NDIM), .POINTS(NPTS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // Behavioral copy of the store state
    logic [3:0] pts [NPTS][NDIM];
    logic [3:0] avail [NDIM][NPTS];
    int         avail_cnt [NDIM];
    int         npts_held;

    lhs_pkg::t_rsp rsp_queue [$];
    int    mismatches;
    int    rsp_seen;
    int    cycles;
    int    req_sent;
    int    mode_hits [8];
    int    status_hits [4];

    // Clock and cycle limit
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending", cycles,
                     rsp_queue.size());
            $display("[latin_hypercube_maximin_store] ERROR");
            $finish;
        end
    end

    function automatic void store_clear();
        for (int d = 0; d < NDIM; d++) begin
            for (int j = 0; j < NPTS; j++) avail[d][j] = j[3:0];
            avail_cnt[d] = NPTS;
        end
        npts_held = 0;
    endfunction

    function automatic int sq_gap(logic [3:0] a [NDIM], logic [3:0] b [NDIM]);
        int s = 0;
        int x;
        for (int d = 0; d < NDIM; d++) begin
            x = int'(a[d]) - int'(b[d]);
            s += x * x;
        end
        return s;
    endfunction

    function automatic int nearest_gap(logic [3:0] c [NDIM]);
        int best = 1 << 30;
        int g;
        if (npts_held == 0) return 0;
        for (int i = 0; i < npts_held; i++) begin
            g = sq_gap(pts[i], c);
            if (g < best) best = g;
        end
        return best;
    endfunction

    // Work out the response for one request and advance the store copy
    function automatic lhs_pkg::t_rsp predict_store(lhs_pkg::t_req r);
        lhs_pkg::t_rsp o;
        logic [3:0] c [NDIM];
        int         at [NDIM];
        int         g;
        int         best;
        logic       hit;
        logic [1:0] st;
        st = lhs_pkg::ST_OK;
        g = 0;
        o = '0;
        case (r.mode)
            lhs_pkg::MODE_ADD_IDX, lhs_pkg::MODE_PROBE, lhs_pkg::MODE_ADD_COORD: begin
                if (r.mode != lhs_pkg::MODE_PROBE && npts_held >= NPTS) begin
                    st = lhs_pkg::ST_FULL;
                end else begin
                    for (int d = 0; d < NDIM; d++) begin
                        if (st == lhs_pkg::ST_OK) begin
                            if (r.mode == lhs_pkg::MODE_ADD_COORD) begin
                                hit = 1'b0;
                                for (int j = 0; j < avail_cnt[d]; j++)
                                    if (!hit && avail[d][j] == r.packed_values[4*d +: 4]) begin
                                        hit = 1'b1;
                                        at[d] = j;
                                    end
                                if (!hit) st = lhs_pkg::ST_RANGE;
                            end else begin
                                at[d] = int'(r.packed_values[4*d +: 4]);
                                if (at[d] >= avail_cnt[d]) st = lhs_pkg::ST_RANGE;
                            end
                            if (st == lhs_pkg::ST_OK) c[d] = avail[d][at[d]];
                        end
                    end
                    if (st == lhs_pkg::ST_OK) begin
                        g = nearest_gap(c);
                        if (r.mode != lhs_pkg::MODE_PROBE) begin
                            // swap-remove the used entries, then store the point
                            for (int d = 0; d < NDIM; d++) begin
                                avail[d][at[d]] = avail[d][avail_cnt[d] - 1];
                                avail_cnt[d]--;
                            end
                            pts[npts_held] = c;
                            npts_held++;
                        end
                        for (int d = 0; d < NDIM; d++) o.resolved_point[4*d +: 4] = c[d];
                    end
                end
            end
            lhs_pkg::MODE_PAIRWISE: begin
                if (npts_held > 1) begin
                    best = 1 << 30;
                    for (int i = 0; i < npts_held - 1; i++)
                        for (int j = i + 1; j < npts_held; j++)
                            if (sq_gap(pts[i], pts[j]) < best) best = sq_gap(pts[i], pts[j]);
                    g = best;
                end
            end
            lhs_pkg::MODE_CLEAR: store_clear();
            default: st = lhs_pkg::ST_RANGE;
        endcase
        if (g > 1023) g = 1023;
        o.distance = g[9:0];
        o.point_count = npts_held[4:0];
        o.status = st;
        status_hits[st]++;
        return o;
    endfunction

    // Send one request, with a random gap after it now and then
    task automatic send_req(input logic [2:0] m, input logic [15:0] v);
        lhs_pkg::t_req r;
        r.mode = m;
        r.packed_values = v;
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        rsp_queue.push_back(predict_store(r));
        mode_hits[m]++;
        req_sent++;
        // hold valid into the next request during a burst, drop it on a gap
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Receiver stall pattern: long open stretches and bursts of stalls
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 200;
            if (stall_phase < 60) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Check each delivered response against the oldest expectation
    always @(posedge i_clk) begin
        lhs_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            rsp_seen++;
            if (rsp_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", o_rsp);
            end else begin
                want = rsp_queue.pop_front();
                if (want !== o_rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected dist=%0d pt=%h cnt=%0d st=%0d,",
                                  " got dist=%0d pt=%h cnt=%0d st=%0d"},
                                 want.distance, want.resolved_point, want.point_count,
                                 want.status, o_rsp.distance, o_rsp.resolved_point,
                                 o_rsp.point_count, o_rsp.status);
                end
            end
        end
    end

    // Drop valid, then wait until every expected response has arrived
    task automatic drain();
        i_valid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_corners();
        // queries on an empty store, bad modes, out-of-range index
        send_req(lhs_pkg::MODE_PAIRWISE, 16'h0000);
        send_req(lhs_pkg::MODE_PROBE, 16'h0000);
        send_req(lhs_pkg::MODE_PROBE, 16'hFFFF);
        send_req(3'd5, 16'h1234);
        send_req(3'd6, 16'hFFFF);
        send_req(3'd7, 16'h0000);
        send_req(lhs_pkg::MODE_ADD_IDX, 16'h0000);
        send_req(lhs_pkg::MODE_PROBE, 16'h0000);
        send_req(lhs_pkg::MODE_PAIRWISE, 16'h0000);
        send_req(lhs_pkg::MODE_ADD_COORD, 16'hFFFF);
        send_req(lhs_pkg::MODE_ADD_COORD, 16'hFFFF);       // value already used
        send_req(lhs_pkg::MODE_ADD_IDX, 16'hF000);         // index past remaining count
        send_req(lhs_pkg::MODE_ADD_COORD, 16'h8888);
        send_req(lhs_pkg::MODE_PAIRWISE, 16'h0000);
        send_req(lhs_pkg::MODE_CLEAR, 16'h0000);
        send_req(lhs_pkg::MODE_PAIRWISE, 16'h0000);
    endtask

    task automatic test_fill_full();
        // fill the store, then try adds, a probe and a pairwise query on it, and clear it
        for (int k = 0; k < NPTS; k++) send_req(lhs_pkg::MODE_ADD_IDX, 16'h0000);
        send_req(lhs_pkg::MODE_ADD_IDX, 16'h0000);
        send_req(lhs_pkg::MODE_ADD_COORD, 16'h0000);
        send_req(lhs_pkg::MODE_PROBE, 16'h0000);
        send_req(lhs_pkg::MODE_PAIRWISE, 16'h0000);
        send_req(lhs_pkg::MODE_CLEAR, 16'h0000);
    endtask

    function automatic logic [15:0] valid_idx();
        logic [15:0] v = '0;
        for (int d = 0; d < NDIM; d++)
            if (avail_cnt[d] > 0) v[4*d +: 4] = 4'($urandom_range(0, avail_cnt[d] - 1));
        return v;
    endfunction

    function automatic logic [15:0] valid_coord();
        logic [15:0] v = '0;
        for (int d = 0; d < NDIM; d++)
            if (avail_cnt[d] > 0) v[4*d +: 4] = avail[d][$urandom_range(0, avail_cnt[d] - 1)];
        return v;
    endfunction

    task automatic test_random_builds(input int n);
        int pick;
        logic [15:0] v;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            v = 16'($urandom_range(0, 16'hFFFF));
            if (pick < 30) send_req(lhs_pkg::MODE_ADD_IDX, valid_idx());
            else if (pick < 50) send_req(lhs_pkg::MODE_ADD_COORD, valid_coord());
            else if (pick < 68) send_req(lhs_pkg::MODE_PROBE, valid_idx());
            else if (pick < 78) send_req(lhs_pkg::MODE_PAIRWISE, v);
            else if (pick < 82) send_req(lhs_pkg::MODE_CLEAR, v);
            else if (pick < 86) send_req(3'($urandom_range(5, 7)), v);
            else send_req(3'($urandom_range(0, 2)), v);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        cycles = 0;
        mismatches = 0;
        rsp_seen = 0;
        req_sent = 0;
        foreach (mode_hits[m]) mode_hits[m] = 0;
        foreach (status_hits[s]) status_hits[s] = 0;
        for (int i = 0; i < NPTS; i++)
            for (int d = 0; d < NDIM; d++) pts[i][d] = '0;
        store_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corners();
        test_fill_full();
        test_random_builds(1060);
        drain();
        repeat (400) @(posedge i_clk);

        $display("covered %0d requests (modes 0..7: %0d %0d %0d %0d %0d %0d %0d %0d)",
                 req_sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
        $display("%0d responses checked; status ok/full/range %0d/%0d/%0d, %0d mismatches",
                 rsp_seen, status_hits[0], status_hits[1], status_hits[2], mismatches);
        if (mismatches == 0 && rsp_queue.size() == 0) begin
            $display("[latin_hypercube_maximin_store] OK");
        end else begin
            $display("[latin_hypercube_maximin_store] ERROR");
        end
        $finish;
    end
endmodule
